// ===== sv/vsp_pkg.sv =====
// Package for the version string parser: types, codes and character constants.
`default_nettype none
package vsp_pkg;

   // default string length limit
   localparam int MAX_STRING_LEN_DEF = 255;

   localparam int MAG_W     = 31;
   localparam int COMP_W    = 32;
   localparam int OFFSET_W  = 8;

   localparam logic [MAG_W-1:0] MAG_MAX     = 31'h7FFF_FFFF;
   localparam logic [MAG_W-1:0] MAG_TEN_MAX = MAG_MAX / 10;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_V     = 8'h76;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_FIRST,
      PH_LATER,
      PH_SEP
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_NEG,
      KIND_TEN
   } kind_type;

   typedef enum logic [1:0] {
      ST_COMPONENT,
      ST_NOT_VERSION,
      ST_UNDER_BEFORE_DOT,
      ST_MULTI_UNDER
   } status_type;

   typedef struct packed {
      logic [COMP_W-1:0]   component;
      logic                last;
      status_type          status;
      logic                overflow;
      logic [OFFSET_W-1:0] end_offset;
   } rsp_type;

endpackage : vsp_pkg
`default_nettype wire

// ===== sv/version_string_parser.sv =====
// Version string parser: one character per transfer, numeric components out.
// A result enters the output buffer on the character transfer that causes it; rsp_ shows its head.
// Throughput: one character per cycle while req_ready is high; parse state and multiply-by-ten
// accumulate per transfer; a two-entry output buffer keeps req_ready high while a result waits.
// Reset (synchronous, active high): parser idle until string_start, output buffer empty.
`default_nettype none
module version_string_parser #(
   parameter int MAX_STRING_LEN = vsp_pkg::MAX_STRING_LEN_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_string_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_component,
   output logic             rsp_last,
   output logic [1:0]       rsp_status,
   output logic             rsp_overflow,
   output logic [7:0]       rsp_end_offset
);
   import vsp_pkg::*;

   localparam int CNT_W = $clog2(MAX_STRING_LEN + 1);
   localparam int POS_W = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;
   localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(MAX_STRING_LEN);

   // parse state
   phase_type        phase_ff, phase_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   kind_type         kind_ff, kind_in;
   logic             saw_under_ff, saw_under_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             pend_under_ff, pend_under_in;

   // output buffer
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   // combinational result of the current character
   rsp_type          res;
   logic             res_valid;

   phase_type        ph;
   logic [MAG_W-1:0] cur_mag;
   kind_type         cur_kind;
   logic             cur_ovf;
   logic [CNT_W-1:0] pos;
   logic [POS_W-1:0] pos_wide;
   logic [POS_W-1:0] pos_prev;
   logic [7:0]       ch;
   logic [3:0]       dval;
   logic             is_digit;
   logic             is_alpha;
   logic [MAG_W+3:0] acc;
   logic [MAG_W+3:0] ten_prod;
   logic [MAG_W-1:0] emit_mag;
   logic             emit_ovf;
   logic [COMP_W-1:0] emit_val;

   logic xfer_in;
   logic drain;

   assign req_ready = !skid_valid_ff;
   assign xfer_in   = req_valid && req_ready;
   assign drain     = out_valid_ff && rsp_ready;

   assign pos_wide = POS_W'(pos);
   assign pos_prev = pos_wide - POS_W'(1);

   // work out the next parse state and any result for this character
   always_comb begin
      // restart on string start
      if (req_string_start) begin
         ph       = PH_START;
         cur_mag  = '0;
         cur_kind = KIND_PLAIN;
         cur_ovf  = 1'b0;
         pos      = '0;
         saw_under_in  = 1'b0;
         pend_under_in = 1'b0;
      end else begin
         ph       = phase_ff;
         cur_mag  = mag_ff;
         cur_kind = kind_ff;
         cur_ovf  = ovf_ff;
         pos      = count_ff;
         saw_under_in  = saw_under_ff;
         pend_under_in = pend_under_ff;
      end

      phase_in = ph;
      mag_in   = cur_mag;
      kind_in  = cur_kind;
      ovf_in   = cur_ovf;
      count_in = pos;

      // treat characters beyond the length limit as NUL
      if (pos >= LEN_LIMIT) begin
         ch = CHAR_NUL;
      end else begin
         ch       = req_char_code;
         count_in = pos + CNT_W'(1);
      end

      is_digit = ch inside {[CHAR_ZERO:CHAR_NINE]};
      is_alpha = ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
      dval     = 4'(ch - CHAR_ZERO);

      // accumulate: magnitude times ten plus digit, saturating
      acc = ({1'b0, cur_mag, 3'b000} + {3'b000, cur_mag, 1'b0}) + (MAG_W+4)'(dval);

      // component as emitted, with the times-ten step applied
      ten_prod = {1'b0, cur_mag, 3'b000} + {3'b000, cur_mag, 1'b0};
      emit_mag = cur_mag;
      emit_ovf = cur_ovf;
      if (cur_kind == KIND_TEN) begin
         if (cur_mag > MAG_TEN_MAX) begin
            emit_mag = MAG_MAX;
            emit_ovf = 1'b1;
         end else begin
            emit_mag = ten_prod[MAG_W-1:0];
         end
      end
      if (cur_kind == KIND_NEG) begin
         emit_val = -{1'b0, emit_mag};
      end else begin
         emit_val = {1'b0, emit_mag};
      end

      res_valid      = 1'b0;
      res.component  = emit_val;
      res.last       = 1'b0;
      res.status     = ST_COMPONENT;
      res.overflow   = emit_ovf;
      res.end_offset = '0;

      case (ph)
         PH_IDLE: begin
            // ignore idle characters, hold state
            count_in = count_ff;
         end
         PH_START, PH_FIRST, PH_LATER, PH_SEP: begin
            if (ph == PH_START && ch == CHAR_V) begin
               // skip leading 'v'
               phase_in = PH_FIRST;
            end else if (ph == PH_SEP) begin
               res_valid = 1'b1;
               if (is_digit) begin
                  // separator confirmed: emit and start next component
                  mag_in   = MAG_W'(dval);
                  ovf_in   = 1'b0;
                  phase_in = PH_LATER;
                  if (pend_under_in) begin
                     kind_in = (ch == CHAR_ZERO) ? KIND_TEN : KIND_NEG;
                  end else begin
                     kind_in = KIND_PLAIN;
                  end
               end else begin
                  // separator without digit ends the string
                  res.last       = 1'b1;
                  res.end_offset = pos_prev[7:0];
                  phase_in       = PH_IDLE;
               end
            end else if (is_digit) begin
               phase_in = (ph == PH_START) ? PH_FIRST : ph;
               if (acc > (MAG_W+4)'(MAG_MAX)) begin
                  mag_in = MAG_MAX;
                  ovf_in = 1'b1;
               end else begin
                  mag_in = acc[MAG_W-1:0];
               end
            end else if ((ph == PH_START || ph == PH_FIRST) && is_alpha) begin
               // letter before the first separator (other than a leading v): not a version
               res_valid     = 1'b1;
               res.component = '0;
               res.last      = 1'b1;
               res.status    = ST_NOT_VERSION;
               res.overflow  = 1'b0;
               phase_in      = PH_IDLE;
            end else if (ch == CHAR_DOT || ch == CHAR_UNDER) begin
               if (saw_under_in) begin
                  // separator error, drop the pending component
                  res_valid      = 1'b1;
                  res.component  = '0;
                  res.last       = 1'b1;
                  res.status     = (ch == CHAR_DOT) ? ST_UNDER_BEFORE_DOT : ST_MULTI_UNDER;
                  res.overflow   = 1'b0;
                  res.end_offset = pos_wide[7:0];
                  phase_in       = PH_IDLE;
               end else begin
                  if (ch == CHAR_UNDER) begin
                     saw_under_in = 1'b1;
                  end
                  pend_under_in = (ch == CHAR_UNDER);
                  phase_in      = PH_SEP;
               end
            end else begin
               // any other character ends the string
               res_valid      = 1'b1;
               res.last       = 1'b1;
               res.end_offset = pos_wide[7:0];
               phase_in       = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // advance the parse state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         mag_ff        <= '0;
         kind_ff       <= KIND_PLAIN;
         saw_under_ff  <= 1'b0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_under_ff <= 1'b0;
      end else if (xfer_in) begin
         phase_ff      <= phase_in;
         mag_ff        <= mag_in;
         kind_ff       <= kind_in;
         saw_under_ff  <= saw_under_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         pend_under_ff <= pend_under_in;
      end
   end

   // steer results into the output register or the skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (xfer_in && res_valid) begin
         if (!out_valid_ff || drain) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_component  = out_ff.component;
   assign rsp_last       = out_ff.last;
   assign rsp_status     = out_ff.status;
   assign rsp_overflow   = out_ff.overflow;
   assign rsp_end_offset = out_ff.end_offset;

endmodule : version_string_parser
`default_nettype wire

// ===== bench/version_string_parser_tb.sv =====
// Self-checking bench for the version string parser: directed table, random strings, stalls.
module version_string_parser_tb;
   import vsp_pkg::*;

   localparam int PERIOD        = 12;
   localparam int RESET_CYCLES  = 6;
   localparam int LONG_HOLD     = 80;
   localparam int SETTLE_CYCLES = 16;
   localparam int LIMIT_CYCLES  = 300000;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_CHARS  = 170;
   localparam int QUIET_CHARS   = 50;

   // one row of the directed table; typed rows carry their result written out
   typedef struct {
      logic [7:0] ch;
      logic       first;
      bit         typed;
      int         comp;
      logic       fin;
      status_type code;
      logic       ovf;
      logic [7:0] off;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_string_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_component;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic        rsp_overflow;
   logic [7:0]  rsp_end_offset;

   // typed result travelling with the character on offer
   logic        want_typed = 1'b0;
   rsp_type     want_result = '0;

   // mirror of the parse state
   phase_type   p_phase;
   logic [30:0] p_mag;
   kind_type    p_kind;
   bit          p_saw_under;
   int unsigned p_count;
   bit          p_ovf;
   bit          p_pend_under;

   rsp_type     component_queue [$];
   logic [7:0]  text_q [$];

   bit tx_idle_ok = 1'b1;
   bit rx_idle_ok = 1'b1;
   bit hold_request = 1'b0;

   int failures = 0;
   int results_checked = 0;
   int chars_taken = 0;
   int strings_seen = 0;
   int saturated = 0;
   int status_seen [4];

   dir_row_type directed_rows [27] = '{
      '{CHAR_V,     1'b1, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"1",        1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_DOT,   1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"2",        1'b0, 1'b1, 1, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_DOT,   1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{8'hFF,      1'b0, 1'b1, 2, 1'b1, ST_COMPONENT,        1'b0, 8'd4},
      '{CHAR_NUL,   1'b1, 1'b1, 0, 1'b1, ST_COMPONENT,        1'b0, 8'd0},
      '{"a",        1'b1, 1'b1, 0, 1'b1, ST_NOT_VERSION,      1'b0, 8'd0},
      '{"7",        1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"4",        1'b1, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"8",        1'b1, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_UNDER, 1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"5",        1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_NUL,   1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"1",        1'b1, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_UNDER, 1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"2",        1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_DOT,   1'b0, 1'b1, 0, 1'b1, ST_UNDER_BEFORE_DOT, 1'b0, 8'd3},
      '{"9",        1'b1, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_UNDER, 1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_ZERO,  1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"7",        1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{" ",        1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"1",        1'b1, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_UNDER, 1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{"2",        1'b0, 1'b0, 0, 1'b0, ST_COMPONENT,        1'b0, 8'd0},
      '{CHAR_UNDER, 1'b0, 1'b1, 0, 1'b1, ST_MULTI_UNDER,      1'b0, 8'd3}
   };

   version_string_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_component    (rsp_component),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .rsp_overflow     (rsp_overflow),
      .rsp_end_offset   (rsp_end_offset)
   );

   always #(PERIOD / 2) clock = ~clock;

   // drop any parse in progress
   function automatic void clear_parse();
      p_phase      = PH_IDLE;
      p_mag        = '0;
      p_kind       = KIND_PLAIN;
      p_saw_under  = 1'b0;
      p_count      = 0;
      p_ovf        = 1'b0;
      p_pend_under = 1'b0;
   endfunction

   // value of the pending component, with the times-ten step and beta sign applied
   function automatic rsp_type component_value(input logic fin, input int unsigned off);
      logic [30:0] m;
      logic        ov;
      rsp_type     r;
      m  = p_mag;
      ov = p_ovf;
      if (p_kind == KIND_TEN) begin
         if (m > MAG_TEN_MAX) begin
            m  = MAG_MAX;
            ov = 1'b1;
         end else begin
            m = m * 10;
         end
      end
      r.component  = (p_kind == KIND_NEG) ? -{1'b0, m} : {1'b0, m};
      r.last       = fin;
      r.status     = ST_COMPONENT;
      r.overflow   = ov;
      r.end_offset = fin ? off[7:0] : 8'd0;
      return r;
   endfunction

   // advance the mirror by one character and report the result it causes
   function automatic void parse_char(input logic [7:0] code, input logic first,
                                      output bit yields, output rsp_type res);
      logic [7:0]      c;
      int unsigned     pos;
      bit              digit;
      bit              letter;
      longint unsigned acc;
      yields = 1'b0;
      res    = '0;
      c      = code;
      if (first) begin
         clear_parse();
         p_phase = PH_START;
      end
      if (p_phase == PH_IDLE) return;

      // past the length limit every character reads as NUL
      pos = p_count;
      if (pos >= MAX_STRING_LEN_DEF) c = CHAR_NUL;
      else p_count = pos + 1;

      digit  = c >= CHAR_ZERO && c <= CHAR_NINE;
      letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");

      if (p_phase == PH_START) begin
         p_phase = PH_FIRST;
         if (c == CHAR_V) return;
      end

      yields = 1'b1;
      if (p_phase == PH_SEP) begin
         if (digit) begin
            res     = component_value(1'b0, 0);
            p_mag   = c - CHAR_ZERO;
            p_ovf   = 1'b0;
            if (!p_pend_under) p_kind = KIND_PLAIN;
            else if (c == CHAR_ZERO) p_kind = KIND_TEN;
            else p_kind = KIND_NEG;
            p_phase = PH_LATER;
         end else begin
            // separator with no digit after it ends the string there
            res     = component_value(1'b1, pos - 1);
            p_phase = PH_IDLE;
         end
      end else if (digit) begin
         yields = 1'b0;
         acc    = p_mag;
         acc    = acc * 10 + (c - CHAR_ZERO);
         if (acc > MAG_MAX) begin
            acc   = MAG_MAX;
            p_ovf = 1'b1;
         end
         p_mag = acc[30:0];
      end else if (p_phase == PH_FIRST && letter) begin
         res.last   = 1'b1;
         res.status = ST_NOT_VERSION;
         p_phase    = PH_IDLE;
      end else if (c == CHAR_DOT || c == CHAR_UNDER) begin
         if (p_saw_under) begin
            res.last       = 1'b1;
            res.status     = (c == CHAR_DOT) ? ST_UNDER_BEFORE_DOT : ST_MULTI_UNDER;
            res.end_offset = pos[7:0];
            p_phase        = PH_IDLE;
         end else begin
            yields       = 1'b0;
            p_saw_under  = p_saw_under || c == CHAR_UNDER;
            p_pend_under = c == CHAR_UNDER;
            p_phase      = PH_SEP;
         end
      end else begin
         res     = component_value(1'b1, pos);
         p_phase = PH_IDLE;
      end
   endfunction

   function automatic logic [7:0] char_between(input logic [7:0] lo, input logic [7:0] hi);
      int unsigned v;
      v = $urandom_range(hi, lo);
      return v[7:0];
   endfunction

   task automatic add_digits(input int n, input bit zero_first);
      for (int i = 0; i < n; i++)
         text_q.push_back((i == 0 && zero_first) ? CHAR_ZERO : char_between("0", "9"));
   endtask

   // offer one character and hold it until the transfer
   task automatic offer(input logic [7:0] ch, input logic first, input bit typed,
                        input rsp_type want);
      if (tx_idle_ok && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_code    <= ch;
      req_string_start <= first;
      want_typed       <= typed;
      want_result      <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // send the built string, then a few stray characters without a start mark
   task automatic send_text(input int stray);
      foreach (text_q[i]) offer(text_q[i], i == 0, 1'b0, '0);
      repeat (stray) offer(char_between(8'h00, 8'hFF), 1'b0, 1'b0, '0);
   endtask

   // well-formed version: optional v, dotted parts, an underscore only before the last
   task automatic build_version();
      int parts;
      bit tail_under;
      bit under_here;
      text_q.delete();
      if ($urandom_range(0, 2) == 0) text_q.push_back(CHAR_V);
      parts      = $urandom_range(1, 5);
      tail_under = parts > 1 && $urandom_range(0, 2) == 0;
      for (int p = 0; p < parts; p++) begin
         under_here = tail_under && p == parts - 1;
         if (p > 0) text_q.push_back(under_here ? CHAR_UNDER : CHAR_DOT);
         add_digits(($urandom_range(0, 11) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 3),
                    under_here && $urandom_range(0, 2) == 0);
      end
      case ($urandom_range(0, 5))
         0:       text_q.push_back(CHAR_NUL);
         1:       text_q.push_back(char_between(8'h80, 8'hFF));
         2:       text_q.push_back(char_between("a", "z"));
         3:       text_q.push_back(CHAR_DOT);
         default: text_q.push_back(char_between(8'h21, 8'h2D));
      endcase
   endtask

   // mostly good versions, some token soup, some raw noise
   task automatic send_random_string();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
         build_version();
      end else if (pick < 17) begin
         text_q.delete();
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
               0, 1:    add_digits($urandom_range(1, 3), 1'b0);
               2:       text_q.push_back(CHAR_DOT);
               3:       text_q.push_back(CHAR_UNDER);
               4:       text_q.push_back(char_between("A", "z"));
               default: text_q.push_back(CHAR_V);
            endcase
         end
         text_q.push_back(CHAR_NUL);
      end else begin
         text_q.delete();
         repeat ($urandom_range(1, 8)) text_q.push_back(char_between(8'h00, 8'hFF));
      end
      send_text($urandom_range(0, 2));
   endtask

   // hold the input quiet until every owed result has arrived
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (component_queue.size() != 0);
   endtask

   // compare each result transfer, then predict from each character transfer
   always @(posedge clock) begin
      rsp_type want;
      rsp_type res;
      bit      yields;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (component_queue.size() == 0) begin
               if (failures < MAX_REPORTS)
                  $display("unexpected result: comp %0d last %0b status %0d ovf %0b end %0d",
                           rsp_component, rsp_last, rsp_status, rsp_overflow, rsp_end_offset);
               failures++;
            end else begin
               want = component_queue.pop_front();
               if (rsp_component !== want.component || rsp_last !== want.last ||
                   rsp_status !== want.status || rsp_overflow !== want.overflow ||
                   rsp_end_offset !== want.end_offset) begin
                  if (failures < MAX_REPORTS) begin
                     $display("result %0d expected: comp %0d last %0b status %0d ovf %0b end %0d",
                              results_checked, $signed(want.component), want.last, want.status,
                              want.overflow, want.end_offset);
                     $display("result %0d actual:   comp %0d last %0b status %0d ovf %0b end %0d",
                              results_checked, rsp_component, rsp_last, rsp_status,
                              rsp_overflow, rsp_end_offset);
                  end
                  failures++;
               end
               results_checked++;
               status_seen[rsp_status]++;
               if (rsp_overflow) saturated++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_string_start) strings_seen++;
            if (req_string_start || p_phase != PH_IDLE) chars_taken++;
            parse_char(req_char_code, req_string_start, yields, res);
            if (want_typed) begin
               yields = 1'b1;
               res    = want_result;
            end
            if (yields) component_queue.push_back(res);
         end
      end
   end

   // result side: random stalls, and one long hold-off on request
   initial begin : receiver
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (rx_idle_ok && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * PERIOD);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      dir_row_type row;
      rsp_type     want;
      int          base;
      clear_parse();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         row  = directed_rows[i];
         want = '{component: row.comp, last: row.fin, status: row.code,
                  overflow: row.ovf, end_offset: row.off};
         offer(row.ch, row.first, row.typed, want);
      end
      drain();

      // long receiver hold-off while versions keep coming, so the input backs up
      tx_idle_ok   = 1'b0;
      hold_request = 1'b1;
      repeat (10) begin
         build_version();
         send_text(0);
      end
      tx_idle_ok = 1'b1;
      drain();

      // overlong string: a saturating first part, then a dotted run cut at the limit
      text_q.delete();
      text_q.push_back("9");
      add_digits(11, 1'b0);
      repeat (125) begin
         text_q.push_back(CHAR_DOT);
         add_digits(1, 1'b0);
      end
      send_text(0);

      base = chars_taken;
      while (chars_taken - base < RANDOM_CHARS - QUIET_CHARS) send_random_string();

      // final stretch at full rate on both sides
      tx_idle_ok = 1'b0;
      rx_idle_ok = 1'b0;
      while (chars_taken - base < RANDOM_CHARS) send_random_string();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Parsed %0d strings (%0d characters taken), checked %0d results, %0d saturated.",
               strings_seen, chars_taken, results_checked, saturated);
      $display("By status: %0d components, %0d non-versions, %0d underscore-before-period,",
               status_seen[0], status_seen[1], status_seen[2]);
      $display("           %0d repeated-underscore.", status_seen[3]);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches in total", failures);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/vsp_pkg.sv
sv/version_string_parser.sv
bench/version_string_parser_tb.sv
